// File: hdl/crt_pkg.sv
// Shared types, codes and constants for the cyclic on/off relay timer.
package crt_pkg;

  localparam int unsigned HOURS_W  = 7;
  localparam int unsigned MINS_W   = 6;
  localparam int unsigned SECS_W   = 6;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned MODE_W   = 2;

  // total seconds of one phase, out-of-range fields included (127h 63m 63s)
  localparam int unsigned TOTSEC_W = 19;

  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned MS_PER_SEC   = 1000;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 56;

  // register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ON_HOURS    = 3'd0,
    REG_ON_MINUTES  = 3'd1,
    REG_ON_SECONDS  = 3'd2,
    REG_OFF_HOURS   = 3'd3,
    REG_OFF_MINUTES = 3'd4,
    REG_OFF_SECONDS = 3'd5,
    REG_CYCLE_LIMIT = 3'd6
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ARM    = 2'd0,
    FUNC_STOP   = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_SHIFT  = 2'd3
  } func_t;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;

  // settings seen by the timing core
  typedef struct packed {
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
    logic [LIMIT_W-1:0] cycle_limit;
  } crt_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] paused_ms;
    logic [MODE_W-1:0] sys_mode;
    logic [TIME_W-1:0] now_ms;
    func_t             func;
  } crt_in_t;

  typedef struct packed {
    logic [TIME_W-1:0]  remaining_ms;
    logic               done_res;
    logic [COUNT_W-1:0] cycles_completed;
    logic               in_off_phase;
    logic               relay_on;
  } crt_res_t;

endpackage

// File: hdl/crt_cfg.sv
// Configuration registers and phase duration conversion to milliseconds.
module crt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [crt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  output crt_pkg::crt_cfg_t              cfg
);
  import crt_pkg::*;

  logic [HOURS_W-1:0]  on_h_r,  off_h_r;
  logic [MINS_W-1:0]   on_m_r,  off_m_r;
  logic [SECS_W-1:0]   on_s_r,  off_s_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [TOTSEC_W-1:0] on_sec_r, off_sec_r, on_sec_nxt, off_sec_nxt;
  logic [TIME_W-1:0]   on_ms_r, off_ms_r, on_ms_nxt, off_ms_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_h_r  <= '0;
      on_m_r  <= '0;
      on_s_r  <= SECS_W'(1);
      off_h_r <= '0;
      off_m_r <= '0;
      off_s_r <= SECS_W'(1);
      limit_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_ON_HOURS:    on_h_r  <= cfg_wr_data[HOURS_W-1:0];
        REG_ON_MINUTES:  on_m_r  <= cfg_wr_data[MINS_W-1:0];
        REG_ON_SECONDS:  on_s_r  <= cfg_wr_data[SECS_W-1:0];
        REG_OFF_HOURS:   off_h_r <= cfg_wr_data[HOURS_W-1:0];
        REG_OFF_MINUTES: off_m_r <= cfg_wr_data[MINS_W-1:0];
        REG_OFF_SECONDS: off_s_r <= cfg_wr_data[SECS_W-1:0];
        REG_CYCLE_LIMIT: limit_r <= cfg_wr_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // two registered steps: h/m/s to seconds, then seconds to ms
  always_comb begin
    on_sec_nxt  = TOTSEC_W'(on_h_r)  * TOTSEC_W'(SEC_PER_HOUR)
                + TOTSEC_W'(on_m_r)  * TOTSEC_W'(SEC_PER_MIN) + TOTSEC_W'(on_s_r);
    off_sec_nxt = TOTSEC_W'(off_h_r) * TOTSEC_W'(SEC_PER_HOUR)
                + TOTSEC_W'(off_m_r) * TOTSEC_W'(SEC_PER_MIN) + TOTSEC_W'(off_s_r);
    on_ms_nxt   = TIME_W'(on_sec_r)  * TIME_W'(MS_PER_SEC);
    off_ms_nxt  = TIME_W'(off_sec_r) * TIME_W'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_sec_r  <= TOTSEC_W'(1);
      off_sec_r <= TOTSEC_W'(1);
      on_ms_r   <= TIME_W'(MS_PER_SEC);
      off_ms_r  <= TIME_W'(MS_PER_SEC);
    end else begin
      on_sec_r  <= on_sec_nxt;
      off_sec_r <= off_sec_nxt;
      on_ms_r   <= on_ms_nxt;
      off_ms_r  <= off_ms_nxt;
    end
  end

  assign cfg.on_ms       = on_ms_r;
  assign cfg.off_ms      = off_ms_r;
  assign cfg.cycle_limit = limit_r;

endmodule

// File: hdl/crt_core.sv
// Phase state of the relay channel and the per-transaction result logic.
module crt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pkg::crt_cfg_t cfg,
  input  crt_pkg::crt_in_t  item,
  input  logic              fire,
  output crt_pkg::crt_res_t res
);
  import crt_pkg::*;

  logic               off_r,   off_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  logic [TIME_W-1:0]  len_r,   len_nxt;
  logic [COUNT_W-1:0] cnt_r,   cnt_nxt;
  logic               fin_r,   fin_nxt;
  logic               relay_r, relay_nxt;

  logic [TIME_W-1:0]  elapsed_cur, elapsed_rem, shift_amt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               adv, restart;

  always_comb begin
    elapsed_cur = item.now_ms - start_r;
    adv = (item.func == FUNC_UPDATE) && (item.sys_mode == MODE_RUNNING) && !fin_r
          && (elapsed_cur >= len_r);
    cnt_inc = cnt_r + COUNT_W'(1);

    off_nxt   = off_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    relay_nxt = relay_r;
    restart   = 1'b0;

    unique case (item.func)
      FUNC_ARM: begin
        off_nxt   = 1'b0;
        start_nxt = item.now_ms;
        len_nxt   = cfg.on_ms;
        cnt_nxt   = '0;
        fin_nxt   = 1'b0;
        relay_nxt = 1'b1;
        restart   = 1'b1;
      end
      FUNC_STOP: begin
        off_nxt   = 1'b0;
        cnt_nxt   = '0;
        fin_nxt   = 1'b0;
        relay_nxt = 1'b0;
      end
      FUNC_UPDATE: begin
        if (adv) begin
          if (!off_r) begin
            off_nxt   = 1'b1;
            len_nxt   = cfg.off_ms;
            start_nxt = item.now_ms;
            relay_nxt = 1'b0;
            restart   = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
            if ((cfg.cycle_limit != '0) && (cnt_inc >= cfg.cycle_limit)) begin
              // limit reached: stays in OFF phase, relay off
              fin_nxt   = 1'b1;
              relay_nxt = 1'b0;
            end else begin
              off_nxt   = 1'b0;
              len_nxt   = cfg.on_ms;
              start_nxt = item.now_ms;
              relay_nxt = 1'b1;
              restart   = 1'b1;
            end
          end
        end
      end
      FUNC_SHIFT: begin
        start_nxt = start_r + item.paused_ms;
      end
      default: ;
    endcase

    // elapsed against the new start without waiting for start_nxt
    shift_amt   = (item.func == FUNC_SHIFT) ? item.paused_ms : '0;
    elapsed_rem = item.now_ms - start_r - shift_amt;

    res.relay_on         = relay_nxt;
    res.in_off_phase     = off_nxt;
    res.cycles_completed = cnt_nxt;
    res.done_res         = fin_nxt;
    priority if (item.sys_mode == MODE_IDLE) begin
      res.remaining_ms = cfg.on_ms;
    end else if (fin_nxt) begin
      res.remaining_ms = '0;
    end else if (restart) begin
      res.remaining_ms = len_nxt;
    end else if (elapsed_rem >= len_r) begin
      res.remaining_ms = '0;
    end else begin
      res.remaining_ms = len_r - elapsed_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= 1'b0;
      start_r <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
      relay_r <= 1'b0;
    end else if (fire) begin
      off_r   <= off_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
      relay_r <= relay_nxt;
    end
  end

endmodule

// File: hdl/cyclic_on_off_relay_timer.sv
// Top level of the cyclic on/off relay timer: channel registers and handshakes.
//
// Input channel in_*: one transaction per command (arm, stop, update, freeze
// shift) with the current millisecond time, system mode and paused time.
// Output channel out_*: exactly one result transaction per input transaction,
// in order: relay state, phase, cycle count, finished flag, remaining time.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_addr (0..6);
// durations are converted to ms via a seconds register and a ms register;
// the user must make writes while the channel is idle, as the block does
// not enforce it. An accepted input is held in the input register, then
// its result in the result register. Throughput: one transaction per
// cycle while out_tready is high, the core state updating with each result.
// Reset (rst_n low, synchronous): both channels empty, relay off, ON phase,
// count zero, registers back to 1 s ON / 1 s OFF and no cycle limit.
// Stall: while out_tready is low the result holds; one more transaction can
// sit in the input register, after which in_tready drops.
module cyclic_on_off_relay_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  // func[1:0], now_ms[33:2], sys_mode[35:34], paused_ms[67:36], zero pad
  input  logic [crt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // relay_on[0], in_off_phase[1], cycles_completed[17:2], done_res[18],
  // remaining_ms[50:19], zero pad
  output logic [crt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [crt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import crt_pkg::*;

  localparam int unsigned IN_USED_W  = $bits(crt_in_t);
  localparam int unsigned OUT_USED_W = $bits(crt_res_t);

  crt_cfg_t cfg;
  crt_in_t  in_item_r;
  crt_res_t res, out_res_r;
  logic     in_valid_r, out_valid_r;
  logic     in_fire, adv;

  assign in_fire   = in_tvalid && in_tready;
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  crt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  crt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .item  (in_item_r),
    .fire  (adv),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= crt_in_t'(in_tdata[IN_USED_W-1:0]);
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), out_res_r};

endmodule

// File: sim/crt_checker.sv
// Checker for the relay timer: tracks settings, predicts each result and compares it.
module crt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [crt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [crt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_wr_en,
  input  logic [crt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [crt_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output int unsigned                     results_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  localparam int unsigned MAX_REPORTS = 30;

  // settings as last written
  logic [HOURS_W-1:0] on_h, off_h;
  logic [MINS_W-1:0]  on_m, off_m;
  logic [SECS_W-1:0]  on_s, off_s;
  logic [LIMIT_W-1:0] limit_cfg;

  // channel state
  logic               in_off, finished, relay;
  logic [TIME_W-1:0]  start_ms, length_ms;
  logic [COUNT_W-1:0] cycles;

  crt_res_t reports_due[$];

  function automatic logic [TIME_W-1:0] span_ms(logic [HOURS_W-1:0] h,
                                                 logic [MINS_W-1:0] m,
                                                 logic [SECS_W-1:0] s);
    return (TIME_W'(h) * SEC_PER_HOUR + TIME_W'(m) * SEC_PER_MIN + TIME_W'(s)) * MS_PER_SEC;
  endfunction

  function automatic crt_res_t timer_step(crt_in_t cmd);
    crt_res_t          res;
    logic [TIME_W-1:0] elapsed;
    case (cmd.func)
      FUNC_ARM: begin
        in_off    = 1'b0;
        start_ms  = cmd.now_ms;
        length_ms = span_ms(on_h, on_m, on_s);
        cycles    = '0;
        finished  = 1'b0;
        relay     = 1'b1;
      end
      FUNC_STOP: begin
        // phase start and length are kept
        in_off   = 1'b0;
        cycles   = '0;
        finished = 1'b0;
        relay    = 1'b0;
      end
      FUNC_UPDATE: begin
        if (cmd.sys_mode == MODE_RUNNING && !finished) begin
          elapsed = cmd.now_ms - start_ms;
          if (elapsed >= length_ms) begin
            if (!in_off) begin
              in_off    = 1'b1;
              length_ms = span_ms(off_h, off_m, off_s);
              start_ms  = cmd.now_ms;
              relay     = 1'b0;
            end else begin
              cycles = cycles + 1'b1;
              if (limit_cfg != '0 && cycles >= limit_cfg) begin
                // phase stays OFF, start untouched
                finished = 1'b1;
                relay    = 1'b0;
              end else begin
                in_off    = 1'b0;
                length_ms = span_ms(on_h, on_m, on_s);
                start_ms  = cmd.now_ms;
                relay     = 1'b1;
              end
            end
          end
        end
      end
      default: start_ms = start_ms + cmd.paused_ms;
    endcase

    if (cmd.sys_mode == MODE_IDLE) begin
      res.remaining_ms = span_ms(on_h, on_m, on_s);
    end else if (finished) begin
      res.remaining_ms = '0;
    end else begin
      elapsed = cmd.now_ms - start_ms;
      res.remaining_ms = (elapsed >= length_ms) ? '0 : length_ms - elapsed;
    end
    res.relay_on         = relay;
    res.in_off_phase     = in_off;
    res.cycles_completed = cycles;
    res.done_res         = finished;
    return res;
  endfunction

  task automatic check_field(input string fname, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    crt_res_t got, want;
    if (!rst_n) begin
      on_h      = '0;
      on_m      = '0;
      on_s      = SECS_W'(1);
      off_h     = '0;
      off_m     = '0;
      off_s     = SECS_W'(1);
      limit_cfg = '0;
      in_off    = 1'b0;
      start_ms  = '0;
      length_ms = '0;
      cycles    = '0;
      finished  = 1'b0;
      relay     = 1'b0;
      reports_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ON_HOURS:    on_h      = cfg_wr_data[HOURS_W-1:0];
          REG_ON_MINUTES:  on_m      = cfg_wr_data[MINS_W-1:0];
          REG_ON_SECONDS:  on_s      = cfg_wr_data[SECS_W-1:0];
          REG_OFF_HOURS:   off_h     = cfg_wr_data[HOURS_W-1:0];
          REG_OFF_MINUTES: off_m     = cfg_wr_data[MINS_W-1:0];
          REG_OFF_SECONDS: off_s     = cfg_wr_data[SECS_W-1:0];
          REG_CYCLE_LIMIT: limit_cfg = cfg_wr_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        results_seen++;
        got = crt_res_t'(out_tdata[$bits(crt_res_t)-1:0]);
        if (reports_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                     $time, out_tdata);
        end else begin
          want = reports_due.pop_front();
          check_field("relay_on", TIME_W'(want.relay_on), TIME_W'(got.relay_on));
          check_field("in_off_phase", TIME_W'(want.in_off_phase), TIME_W'(got.in_off_phase));
          check_field("cycles_completed", TIME_W'(want.cycles_completed),
                      TIME_W'(got.cycles_completed));
          check_field("done_res", TIME_W'(want.done_res), TIME_W'(got.done_res));
          check_field("remaining_ms", want.remaining_ms, got.remaining_ms);
        end
      end

      if (in_tvalid && in_tready)
        reports_due.push_back(timer_step(crt_in_t'(in_tdata[$bits(crt_in_t)-1:0])));
    end
    pending = reports_due.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the relay timer testbench: clock, reset, stimulus, back-pressure and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import crt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_FROZEN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;
  localparam int unsigned QUIET_LIMIT        = 2000;
  localparam int unsigned TOGGLE_UPDATES     = 40;
  localparam int unsigned RANDOM_PER_SETTING = 95;
  localparam int unsigned RANDOM_SETTINGS    = 5;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

  int unsigned fail_count, pending, results_seen;

  // stimulus shaping
  logic [TIME_W-1:0] clock_ms = '0;
  int unsigned       on_len = 1000, off_len = 1000;
  int unsigned       burst_left = 0;
  logic              steady = 1'b0;

  // receiver
  int unsigned hold_requests = 0, holds_served = 0, hold_left = 0;
  int unsigned pattern_left = 0, stall_pct = 0;

  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  cyclic_on_off_relay_timer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  crt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tdata    (out_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // receiver: random stall patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= 47;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(8, 64);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 30;
          3:       stall_pct <= 60;
          default: stall_pct <= 85;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic crt_in_t pack_cmd(func_t f, logic [MODE_W-1:0] mode,
                                       logic [TIME_W-1:0] now, logic [TIME_W-1:0] paused);
    crt_in_t c;
    c.func      = f;
    c.sys_mode  = mode;
    c.now_ms    = now;
    c.paused_ms = paused;
    return c;
  endfunction

  task automatic send_item(input crt_in_t c);
    int unsigned gap;
    if (!steady && burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= IN_TDATA_W'(c);
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left != 0) burst_left--;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value,
                           input int unsigned w);
    logic [CFG_DATA_W-1:0] junk;
    // unused upper bits carry junk now and then
    junk = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= (junk << w) | value;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned onh, input int unsigned onm,
                            input int unsigned ons, input int unsigned offh,
                            input int unsigned offm, input int unsigned offs,
                            input int unsigned lim);
    write_reg(REG_ON_HOURS,    CFG_DATA_W'(onh),  HOURS_W);
    write_reg(REG_ON_MINUTES,  CFG_DATA_W'(onm),  MINS_W);
    write_reg(REG_ON_SECONDS,  CFG_DATA_W'(ons),  SECS_W);
    write_reg(REG_OFF_HOURS,   CFG_DATA_W'(offh), HOURS_W);
    write_reg(REG_OFF_MINUTES, CFG_DATA_W'(offm), MINS_W);
    write_reg(REG_OFF_SECONDS, CFG_DATA_W'(offs), SECS_W);
    write_reg(REG_CYCLE_LIMIT, CFG_DATA_W'(lim),  LIMIT_W);
    cfg_wr_en <= 1'b0;
    // durations settle through the seconds and ms registers after the write
    repeat (4) @(posedge clk);
    on_len  = (onh * SEC_PER_HOUR + onm * SEC_PER_MIN + ons) * MS_PER_SEC;
    off_len = (offh * SEC_PER_HOUR + offm * SEC_PER_MIN + offs) * MS_PER_SEC;
  endtask

  // mostly running updates that walk time forward, often onto a phase edge
  function automatic crt_in_t random_cmd();
    int unsigned       r, span, hop;
    logic [TIME_W-1:0] paused;
    logic [MODE_W-1:0] mode;
    r    = $urandom_range(0, 99);
    span = (on_len > off_len) ? on_len : off_len;
    mode = MODE_W'($urandom_range(0, 3));
    if ($urandom_range(0, 1) != 0)
      hop = (($urandom_range(0, 1) != 0) ? on_len : off_len) + $urandom_range(0, 2) - 1;
    else
      hop = $urandom_range(0, span + span / 2 + 2);
    if (r < 60) begin
      clock_ms += hop;
      return pack_cmd(FUNC_UPDATE, MODE_RUNNING, clock_ms, $urandom);
    end else if (r < 66) begin
      clock_ms += $urandom_range(0, 50);
      return pack_cmd(FUNC_ARM, mode, clock_ms, $urandom);
    end else if (r < 71) begin
      return pack_cmd(FUNC_STOP, mode, clock_ms, $urandom);
    end else if (r < 83) begin
      paused = ($urandom_range(0, 3) != 0) ? TIME_W'($urandom_range(0, span)) : $urandom;
      clock_ms += paused;
      return pack_cmd(FUNC_SHIFT, mode, clock_ms, paused);
    end else if (r < 95) begin
      clock_ms += hop;
      case ($urandom_range(0, 2))
        0:       mode = MODE_IDLE;
        1:       mode = MODE_FROZEN;
        default: mode = MODE_UNDEF;
      endcase
      return pack_cmd(FUNC_UPDATE, mode, clock_ms, $urandom);
    end else begin
      clock_ms = $urandom;
      return pack_cmd(FUNC_UPDATE, MODE_RUNNING, clock_ms, $urandom);
    end
  endfunction

  initial begin
    logic [TIME_W-1:0] t;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1 s ON, 1 s OFF, no limit
    t = 32'hFFFF_FE00;
    // never armed: zero-length phase lapses at once
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, 32'h0, 32'hFFFF_FFFF));
    send_item(pack_cmd(FUNC_UPDATE, MODE_IDLE, 32'hFFFF_FFFF, 32'h0));
    send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, t, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 999, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 1000, 32'h0));
    send_item(pack_cmd(FUNC_SHIFT, MODE_FROZEN, t + 1000, 32'hFFFF_FFFF));
    send_item(pack_cmd(FUNC_UPDATE, MODE_UNDEF, t + 1500, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_FROZEN, t + 5000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 2000, 32'h0));
    send_item(pack_cmd(FUNC_STOP, MODE_IDLE, t + 2100, 32'h5A5A_A5A5));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, 32'h8000_0000, 32'h0));
    wait_drained();

    // longest legal ON, out-of-range OFF fields, top limit
    set_config(99, 59, 59, 127, 63, 63, 16'hFFFF);
    t = 32'hFFFF_FFFF;
    send_item(pack_cmd(FUNC_UPDATE, MODE_IDLE, 32'h0, 32'h0));
    send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, t, 32'hFFFF_FFFF));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + on_len - 1, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + on_len, 32'h0));
    send_item(pack_cmd(FUNC_SHIFT, MODE_RUNNING, t + on_len + 10, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + on_len + off_len, 32'h0));
    wait_drained();

    // limit written below the count: finishes at the end of the next OFF phase
    set_config(0, 0, 1, 0, 0, 2, 0);
    t = $urandom;
    send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, t, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 1000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 3000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 4000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 6000, 32'h0));
    wait_drained();
    write_reg(REG_CYCLE_LIMIT, CFG_DATA_W'(1), LIMIT_W);
    cfg_wr_en <= 1'b0;
    repeat (4) @(posedge clk);
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 7000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 9000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, t + 20000, 32'h0));
    send_item(pack_cmd(FUNC_UPDATE, MODE_IDLE, t + 20001, 32'h0));
    send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, t + 21000, 32'h0));
    wait_drained();

    // zero-length phases toggle on every update, sent back to back
    set_config(0, 0, 0, 0, 0, 0, 0);
    steady = 1'b1;
    send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, $urandom, $urandom));
    for (int n = 0; n < TOGGLE_UPDATES; n++)
      send_item(pack_cmd(FUNC_UPDATE, MODE_RUNNING, $urandom, $urandom));
    steady = 1'b0;
    wait_drained();

    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      case (s)
        0: set_config(0, 0, 1, 0, 0, 1, 3);
        1: set_config(0, 0, 2, 0, 0, 1, 0);
        2: set_config(0, $urandom_range(0, 1), $urandom_range(0, 59),
                      0, $urandom_range(0, 1), $urandom_range(0, 59), $urandom_range(1, 5));
        3: set_config($urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 65535));
        default: set_config(0, 0, 0, 0, 0, 3, 2);
      endcase
      clock_ms = $urandom;
      send_item(pack_cmd(FUNC_ARM, MODE_RUNNING, clock_ms, $urandom));
      for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
        if (s == 1 && n == 40) begin
          // output held for a long stretch while input keeps coming
          hold_requests <= hold_requests + 1;
          steady = 1'b1;
        end
        if (s == 1 && n == 70) steady = 1'b0;
        if (s == 2 && n == 55) wait_drained();
        send_item(random_cmd());
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    $display("Run covered %0d results: wrapped times, extreme and zero durations,", results_seen);
    $display("a lowered cycle limit, zero-length phase toggling and five random settings.");
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/crt_pkg.sv
hdl/crt_cfg.sv
hdl/crt_core.sv
hdl/cyclic_on_off_relay_timer.sv
sim/crt_checker.sv
sim/testbench.sv
